FILE: hw/rtl/imqm_pkg.sv
`default_nettype none
package imqm_pkg;

  localparam int unsigned MAX_SAMPLES = 4194304;
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  // sums of squared 8-bit values over MAX_SAMPLES samples
  localparam int SUM_W = 38;
  localparam int DVD_W = SUM_W + 16;
  localparam int DIT_W = $clog2(DVD_W + 1);
  localparam int LOG_E_W = 6;
  localparam int LOG_FRAC = 24;
  localparam int LOG_W = LOG_E_W + LOG_FRAC;
  localparam int LIT_W = $clog2(LOG_FRAC + 1);
  localparam int MANT_W = 31;
  localparam logic [LOG_W-1:0] DB_PER_OCTAVE_Q28 = 30'd808071242;

  typedef enum logic [3:0] {
    S_ACC, S_MSE_GO, S_MSE_WAIT, S_PM_GO, S_PM_WAIT, S_LS_GO, S_LS_WAIT,
    S_LE_GO, S_LE_WAIT, S_LD_GO, S_LD_WAIT, S_DB_SNR, S_DB_PSNR, S_LOAD, S_OUT
  } ctl_state_e;

  typedef enum logic [0:0] {DIV_MSE, DIV_PMSE} div_sel_e;
  typedef enum logic [1:0] {LOG_SSE, LOG_ENERGY, LOG_DEN} log_sel_e;
  typedef enum logic [1:0] {LP_IDLE, LP_NORM, LP_MUL, LP_ADJ} log_phase_e;

  typedef struct packed {
    logic     acc_en;
    logic     clear;
    logic     div_start;
    div_sel_e div_sel;
    logic     log_start;
    log_sel_e log_sel;
    logic     db_snr;
    logic     db_psnr;
    logic     load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic log_done;
  } dp_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/image_mse_psnr_meter.sv
// channel | direction | handshake               | payload
// in      | sink      | in_valid_i / in_stall_o  | first_pixel_i, second_pixel_i, last_i
// out     | source    | out_valid_o / out_stall_i| mse_q8_o .. count_overflow_o
//
// one sample pair per cycle while accumulating; a transfer with last set
// starts the result pass: two serial divides of 54 quotient bits each,
// then three log2 runs in the shared squaring unit, then the dB steps
// for SNR and PSNR and the load of the result registers, after which
// out_valid_o rises
// reset (rst_ni low, asynchronous) clears all sums, maxima, count and flags
// input is stalled from the last transfer until the result transfer completes
`default_nettype none
module image_mse_psnr_meter import imqm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  first_pixel_i,
  input  wire logic [7:0]  second_pixel_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [23:0]      mse_q8_o,
  output logic [31:0]      pmse_q16_o,
  output logic signed [15:0] snr_db_q8_o,
  output logic signed [15:0] psnr_db_q8_o,
  output logic [7:0]       max_abs_diff_o,
  output logic [7:0]       peak_value_o,
  output logic             identical_o,
  output logic             reference_all_zero_o,
  output logic             count_overflow_o
);

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: accumulate, divide twice, take three logs, form dB, present
  imqm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_i      (last_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // accumulators, divider, log2 unit and result registers
  imqm_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .first_pixel_i        (first_pixel_i),
    .second_pixel_i       (second_pixel_i),
    .mse_q8_o             (mse_q8_o),
    .pmse_q16_o           (pmse_q16_o),
    .snr_db_q8_o          (snr_db_q8_o),
    .psnr_db_q8_o         (psnr_db_q8_o),
    .max_abs_diff_o       (max_abs_diff_o),
    .peak_value_o         (peak_value_o),
    .identical_o          (identical_o),
    .reference_all_zero_o (reference_all_zero_o),
    .count_overflow_o     (count_overflow_o)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/imqm_div.sv
`default_nettype none
module imqm_div import imqm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [SUM_W-1:0] divisor_i,
  output logic      [DVD_W-1:0] quotient_o,
  output logic                  done_o
);

  logic             busy_q;
  logic [DIT_W-1:0] cnt_q;
  logic             done_q;
  logic [SUM_W-1:0] rem_q;
  logic [DVD_W-1:0] quo_q;
  logic [SUM_W-1:0] dvs_q;
  logic [SUM_W:0]   trial;
  logic             ge;
  logic [SUM_W:0]   rem_n;

  // restoring division, one quotient bit a cycle
  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign rem_n = ge ? trial - {1'b0, dvs_q} : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], ge};
      rem_q <= rem_n[SUM_W-1:0];
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule
`default_nettype wire

FILE: hw/rtl/imqm_log2.sv
`default_nettype none
module imqm_log2 import imqm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SUM_W-1:0] value_i,
  output logic      [LOG_W-1:0] result_o,
  output logic                  done_o
);

  log_phase_e          phase_q, phase_d;
  logic                done_q;
  logic [SUM_W-1:0]    m_q;
  logic [LOG_E_W-1:0]  e_q;
  logic [MANT_W-1:0]   mant_q;
  logic [2*MANT_W-1:0] prod_q;
  logic [LOG_FRAC-1:0] frac_q;
  logic [LIT_W-1:0]    it_q;
  logic [MANT_W:0]     sq;
  logic                norm_end;

  assign sq       = prod_q[2*MANT_W-1:MANT_W-1];
  assign norm_end = m_q[SUM_W-1] || (e_q == '0);

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      LP_IDLE: if (start_i) phase_d = LP_NORM;
      LP_NORM: if (norm_end) phase_d = LP_MUL;
      LP_MUL:  phase_d = LP_ADJ;
      LP_ADJ:  phase_d = (it_q == LIT_W'(1)) ? LP_IDLE : LP_MUL;
      default: phase_d = LP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= LP_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= (phase_q == LP_ADJ) && (it_q == LIT_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (phase_q)
      LP_IDLE: begin
        if (start_i) begin
          m_q <= value_i;
          e_q <= LOG_E_W'(SUM_W - 1);
        end
      end
      LP_NORM: begin
        if (norm_end) begin
          mant_q <= m_q[SUM_W-1 -: MANT_W];
          it_q   <= LIT_W'(LOG_FRAC);
          frac_q <= '0;
        end else begin
          m_q <= {m_q[SUM_W-2:0], 1'b0};
          e_q <= e_q - 1'b1;
        end
      end
      LP_MUL: prod_q <= mant_q * mant_q;
      LP_ADJ: begin
        mant_q <= sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
        frac_q <= {frac_q[LOG_FRAC-2:0], sq[MANT_W]};
        it_q   <= it_q - 1'b1;
      end
      default: ;
    endcase
  end

  assign result_o = {e_q, frac_q};
  assign done_o   = done_q;

endmodule
`default_nettype wire

FILE: hw/rtl/imqm_dp.sv
`default_nettype none
module imqm_dp import imqm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     cmd_i,
  output dp_sts_t          sts_o,
  input  wire logic [7:0]  first_pixel_i,
  input  wire logic [7:0]  second_pixel_i,
  output logic [23:0]      mse_q8_o,
  output logic [31:0]      pmse_q16_o,
  output logic signed [15:0] snr_db_q8_o,
  output logic signed [15:0] psnr_db_q8_o,
  output logic [7:0]       max_abs_diff_o,
  output logic [7:0]       peak_value_o,
  output logic             identical_o,
  output logic             reference_all_zero_o,
  output logic             count_overflow_o
);

  logic [SUM_W-1:0] sse_q, en_q, den_q;
  logic [7:0]       ld_q, lr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             ovf_q;
  logic [15:0]      psq_q;
  logic [CNT_W+15:0] den_full;
  logic [7:0]       diff;
  logic [15:0]      dsq, asq;

  logic [DVD_W-1:0] dividend, quotient;
  logic [SUM_W-1:0] divisor, log_in;
  logic             div_done, log_done;
  logic [LOG_W-1:0] log_res;
  logic [LOG_W-1:0] l_sse_q, l_en_q, l_den_q;
  logic [23:0]      mse_q;
  logic [31:0]      pq_q;
  logic [2*LOG_W-1:0] prod_q;
  logic             neg_q;
  logic [15:0]      snr_q;
  logic [LOG_W-1:0] mag_snr, mag_psnr;

  logic [23:0] mse_o_q;
  logic [31:0] pmse_o_q;
  logic [15:0] snr_o_q, psnr_o_q;
  logic [7:0]  maxd_o_q, peak_o_q;
  logic        ident_o_q, rzero_o_q, ovf_o_q;

  function automatic logic [15:0] db_sat(input logic [2*LOG_W-1:0] p, input logic n);
    logic [2*LOG_W:0] s;
    logic [16:0]      r;
    s = {1'b0, p} + ((2*LOG_W+1)'(1) << 43);
    r = s[2*LOG_W:44];
    if (!n) begin
      return (r > 17'd32767) ? 16'h7FFF : r[15:0];
    end else if (r >= 17'd32768) begin
      return 16'h8000;
    end else begin
      return ~r[15:0] + 16'd1;
    end
  endfunction

  assign diff     = (first_pixel_i > second_pixel_i) ? first_pixel_i - second_pixel_i
                                                     : second_pixel_i - first_pixel_i;
  assign dsq      = diff * diff;
  assign asq      = first_pixel_i * first_pixel_i;
  assign den_full = cnt_q * psq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sse_q <= '0;
      en_q  <= '0;
      ld_q  <= '0;
      lr_q  <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.clear) begin
      sse_q <= '0;
      en_q  <= '0;
      ld_q  <= '0;
      lr_q  <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.acc_en) begin
      if (cnt_q == CNT_W'(MAX_SAMPLES)) begin
        ovf_q <= 1'b1;
      end else begin
        sse_q <= sse_q + SUM_W'(dsq);
        en_q  <= en_q + SUM_W'(asq);
        if (diff > ld_q) ld_q <= diff;
        if (first_pixel_i > lr_q) lr_q <= first_pixel_i;
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // peak squared and count times peak squared, settled long before use
  always_ff @(posedge clk_i) begin
    psq_q <= lr_q * lr_q;
    den_q <= den_full[SUM_W-1:0];
  end

  assign dividend = (cmd_i.div_sel == DIV_MSE) ? DVD_W'({sse_q, 8'd0}) : {sse_q, 16'd0};
  assign divisor  = (cmd_i.div_sel == DIV_MSE) ? SUM_W'(cnt_q) : den_q;

  always_comb begin
    unique case (cmd_i.log_sel)
      LOG_SSE:    log_in = sse_q;
      LOG_ENERGY: log_in = en_q;
      LOG_DEN:    log_in = den_q;
      default:    log_in = sse_q;
    endcase
  end

  imqm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  imqm_log2 u_log2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.log_start),
    .value_i  (log_in),
    .result_o (log_res),
    .done_o   (log_done)
  );

  assign mag_snr  = (l_en_q < l_sse_q) ? l_sse_q - l_en_q : l_en_q - l_sse_q;
  assign mag_psnr = (l_den_q < l_sse_q) ? l_sse_q - l_den_q : l_den_q - l_sse_q;

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      if (cmd_i.div_sel == DIV_MSE) begin
        mse_q <= quotient[23:0];
      end else begin
        pq_q <= (quotient[DVD_W-1:32] != '0) ? 32'hFFFF_FFFF : quotient[31:0];
      end
    end
    if (log_done) begin
      unique case (cmd_i.log_sel)
        LOG_SSE:    l_sse_q <= log_res;
        LOG_ENERGY: l_en_q  <= log_res;
        LOG_DEN:    l_den_q <= log_res;
        default:    l_sse_q <= log_res;
      endcase
    end
    if (cmd_i.db_snr) begin
      prod_q <= mag_snr * DB_PER_OCTAVE_Q28;
      neg_q  <= l_en_q < l_sse_q;
    end
    if (cmd_i.db_psnr) begin
      snr_q  <= db_sat(prod_q, neg_q);
      prod_q <= mag_psnr * DB_PER_OCTAVE_Q28;
      neg_q  <= l_den_q < l_sse_q;
    end
    if (cmd_i.load) begin
      mse_o_q   <= mse_q;
      pmse_o_q  <= (sse_q == '0) ? 32'd0 : (den_q == '0) ? 32'hFFFF_FFFF : pq_q;
      snr_o_q   <= (sse_q == '0) ? 16'h7FFF : (en_q == '0) ? 16'h8000 : snr_q;
      psnr_o_q  <= (sse_q == '0) ? 16'h7FFF : (den_q == '0) ? 16'h8000
                                            : db_sat(prod_q, neg_q);
      maxd_o_q  <= ld_q;
      peak_o_q  <= lr_q;
      ident_o_q <= sse_q == '0;
      rzero_o_q <= en_q == '0;
      ovf_o_q   <= ovf_q;
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.log_done = log_done;

  assign mse_q8_o             = mse_o_q;
  assign pmse_q16_o           = pmse_o_q;
  assign snr_db_q8_o          = snr_o_q;
  assign psnr_db_q8_o         = psnr_o_q;
  assign max_abs_diff_o       = maxd_o_q;
  assign peak_value_o         = peak_o_q;
  assign identical_o          = ident_o_q;
  assign reference_all_zero_o = rzero_o_q;
  assign count_overflow_o     = ovf_o_q;

endmodule
`default_nettype wire

FILE: hw/rtl/imqm_ctrl.sv
`default_nettype none
module imqm_ctrl import imqm_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    last_i,
  input  wire logic    out_stall_i,
  input  wire dp_sts_t sts_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  output dp_cmd_t      cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACC;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_ACC: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.acc_en = 1'b1;
          if (last_i) state_d = S_MSE_GO;
        end
      end
      S_MSE_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_MSE;
        state_d         = S_MSE_WAIT;
      end
      S_MSE_WAIT: begin
        cmd_o.div_sel = DIV_MSE;
        if (sts_i.div_done) state_d = S_PM_GO;
      end
      S_PM_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_PMSE;
        state_d         = S_PM_WAIT;
      end
      S_PM_WAIT: begin
        cmd_o.div_sel = DIV_PMSE;
        if (sts_i.div_done) state_d = S_LS_GO;
      end
      S_LS_GO: begin
        cmd_o.log_start = 1'b1;
        cmd_o.log_sel   = LOG_SSE;
        state_d         = S_LS_WAIT;
      end
      S_LS_WAIT: begin
        cmd_o.log_sel = LOG_SSE;
        if (sts_i.log_done) state_d = S_LE_GO;
      end
      S_LE_GO: begin
        cmd_o.log_start = 1'b1;
        cmd_o.log_sel   = LOG_ENERGY;
        state_d         = S_LE_WAIT;
      end
      S_LE_WAIT: begin
        cmd_o.log_sel = LOG_ENERGY;
        if (sts_i.log_done) state_d = S_LD_GO;
      end
      S_LD_GO: begin
        cmd_o.log_start = 1'b1;
        cmd_o.log_sel   = LOG_DEN;
        state_d         = S_LD_WAIT;
      end
      S_LD_WAIT: begin
        cmd_o.log_sel = LOG_DEN;
        if (sts_i.log_done) state_d = S_DB_SNR;
      end
      S_DB_SNR: begin
        cmd_o.db_snr = 1'b1;
        state_d      = S_DB_PSNR;
      end
      S_DB_PSNR: begin
        cmd_o.db_psnr = 1'b1;
        state_d       = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.clear = 1'b1;
          state_d     = S_ACC;
        end
      end
      default: state_d = S_ACC;
    endcase
  end

`ifndef ASSERT_OFF
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");
  a_last_stops_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_i) |=> in_stall_o)
    else $error("input taken right after the last sample");
  a_out_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> (!out_valid_o && !in_stall_o))
    else $error("no return to accumulation after result transfer");
  a_one_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.div_start && cmd_o.log_start))
    else $error("two units started together");
`endif

endmodule
`default_nettype wire
